// ----- rtl/swc_pkg.sv -----
package swc_pkg;

  localparam int unsigned PeriodWidth = 11;

  localparam logic [2:0] OP_TICK    = 3'd0;
  localparam logic [2:0] OP_QUARTER = 3'd1;
  localparam logic [2:0] OP_HALF    = 3'd2;
  localparam logic [2:0] OP_WRITE   = 3'd3;
  localparam logic [2:0] OP_ENABLE  = 3'd4;

  localparam logic [1:0] REG_DUTY_ENV = 2'd0;
  localparam logic [1:0] REG_SWEEP    = 2'd1;
  localparam logic [1:0] REG_PER_LO   = 2'd2;
  localparam logic [1:0] REG_PER_HI   = 2'd3;

  localparam logic [PeriodWidth-1:0] PeriodMax = 11'h7FF;
  localparam logic [3:0] DecayMax = 4'd15;

  typedef struct packed {
    logic [3:0] level;
    logic       active;
  } swc_result_t;

  function automatic logic [7:0] duty_lookup(input logic [1:0] sel);
    logic [7:0] pat;
    case (sel)
      2'd0:    pat = 8'h80;
      2'd1:    pat = 8'hC0;
      2'd2:    pat = 8'hF0;
      default: pat = 8'h3F;
    endcase
    return pat;
  endfunction

  function automatic logic [7:0] length_lookup(input logic [4:0] sel);
    logic [7:0] len;
    case (sel)
      5'd0:  len = 8'd10;   5'd1:  len = 8'd254;
      5'd2:  len = 8'd20;   5'd3:  len = 8'd2;
      5'd4:  len = 8'd40;   5'd5:  len = 8'd4;
      5'd6:  len = 8'd80;   5'd7:  len = 8'd6;
      5'd8:  len = 8'd160;  5'd9:  len = 8'd8;
      5'd10: len = 8'd60;   5'd11: len = 8'd10;
      5'd12: len = 8'd14;   5'd13: len = 8'd12;
      5'd14: len = 8'd26;   5'd15: len = 8'd14;
      5'd16: len = 8'd12;   5'd17: len = 8'd16;
      5'd18: len = 8'd24;   5'd19: len = 8'd18;
      5'd20: len = 8'd48;   5'd21: len = 8'd20;
      5'd22: len = 8'd96;   5'd23: len = 8'd22;
      5'd24: len = 8'd192;  5'd25: len = 8'd24;
      5'd26: len = 8'd72;   5'd27: len = 8'd26;
      5'd28: len = 8'd16;   5'd29: len = 8'd28;
      5'd30: len = 8'd32;   default: len = 8'd30;
    endcase
    return len;
  endfunction

endpackage

// ----- rtl/swc_core.sv -----
module swc_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_wdata_i,
  input  logic                 accept_i,
  input  logic [2:0]           opcode_i,
  input  logic [1:0]           reg_index_i,
  input  logic [7:0]           write_data_i,
  input  logic                 enable_bit_i,
  output swc_pkg::swc_result_t result_o
);
  import swc_pkg::*;

  logic                   neg_q;
  logic [3:0][7:0]        regs_q, regs_d;
  logic [PeriodWidth-1:0] count_q, count_d;
  logic [2:0]             step_q, step_d;
  logic [7:0]             duty_q, duty_d;
  logic                   env_start_q, env_start_d;
  logic [3:0]             env_div_q, env_div_d;
  logic [3:0]             env_decay_q, env_decay_d;
  logic [3:0]             vol_q, vol_d;
  logic [7:0]             len_q, len_d;
  logic                   len_en_q, len_en_d;
  logic [2:0]             sw_div_q, sw_div_d;
  logic                   sw_reload_q, sw_reload_d;

  logic [PeriodWidth-1:0] per_cur, shf_cur, target, per_nxt, shf_nxt;
  logic [PeriodWidth:0]   sum_cur, diff_cur, sum_nxt;
  logic                   mutes_cur, mute;

  always_comb begin
    per_cur   = {regs_q[REG_PER_HI][2:0], regs_q[REG_PER_LO]};
    shf_cur   = per_cur >> regs_q[REG_SWEEP][2:0];
    sum_cur   = {1'b0, per_cur} + {1'b0, shf_cur};
    diff_cur  = {1'b0, per_cur} - {1'b0, shf_cur} - {{PeriodWidth{1'b0}}, neg_q};
    if (regs_q[REG_SWEEP][3]) begin
      target = diff_cur[PeriodWidth] ? '0 : diff_cur[PeriodWidth-1:0];
    end else begin
      target = sum_cur[PeriodWidth-1:0] & PeriodMax;
    end
    mutes_cur = (per_cur < 11'd8) | (~regs_q[REG_SWEEP][3] & sum_cur[PeriodWidth]);
  end

  always_comb begin
    regs_d      = regs_q;
    count_d     = count_q;
    step_d      = step_q;
    duty_d      = duty_q;
    env_start_d = env_start_q;
    env_div_d   = env_div_q;
    env_decay_d = env_decay_q;
    vol_d       = vol_q;
    len_d       = len_q;
    len_en_d    = len_en_q;
    sw_div_d    = sw_div_q;
    sw_reload_d = sw_reload_q;

    if (accept_i) begin
      if (opcode_i == OP_QUARTER || opcode_i == OP_HALF) begin
        if (env_start_q) begin
          env_start_d = 1'b0;
          env_decay_d = DecayMax;
          env_div_d   = regs_q[REG_DUTY_ENV][3:0];
        end else if (env_div_q != 4'd0) begin
          env_div_d = env_div_q - 4'd1;
        end else begin
          env_div_d = regs_q[REG_DUTY_ENV][3:0];
          if (env_decay_q != 4'd0) begin
            env_decay_d = env_decay_q - 4'd1;
          end else if (regs_q[REG_DUTY_ENV][5]) begin
            env_decay_d = DecayMax;
          end
        end
        vol_d = regs_q[REG_DUTY_ENV][4] ? regs_q[REG_DUTY_ENV][3:0] : env_decay_d;
      end

      case (opcode_i)
        OP_TICK: begin
          if (count_q != '0) begin
            count_d = count_q - 11'd1;
          end else begin
            count_d = per_cur;
            step_d  = step_q - 3'd1;
          end
        end
        OP_HALF: begin
          if (sw_div_q == 3'd0 && !mutes_cur && regs_q[REG_SWEEP][7] &&
              regs_q[REG_SWEEP][2:0] != 3'd0) begin
            regs_d[REG_PER_LO]      = target[7:0];
            regs_d[REG_PER_HI][2:0] = target[PeriodWidth-1:8];
          end
          if (sw_reload_q || sw_div_q == 3'd0) begin
            sw_div_d    = regs_q[REG_SWEEP][6:4];
            sw_reload_d = 1'b0;
          end else begin
            sw_div_d = sw_div_q - 3'd1;
          end
          if (len_en_q && len_q != 8'd0 && !regs_q[REG_DUTY_ENV][5]) begin
            len_d = len_q - 8'd1;
          end
        end
        OP_WRITE: begin
          if (reg_index_i == REG_DUTY_ENV) begin
            duty_d = duty_lookup(write_data_i[7:6]);
          end else if (reg_index_i == REG_SWEEP) begin
            sw_reload_d = 1'b1;
          end else if (reg_index_i == REG_PER_HI) begin
            step_d      = 3'd0;
            env_start_d = 1'b1;
            if (len_en_q) begin
              len_d = length_lookup(write_data_i[7:3]);
            end
          end
          regs_d[reg_index_i] = write_data_i;
        end
        OP_ENABLE: begin
          len_en_d = enable_bit_i;
          if (!enable_bit_i) begin
            len_d = 8'd0;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    per_nxt = {regs_d[REG_PER_HI][2:0], regs_d[REG_PER_LO]};
    shf_nxt = per_nxt >> regs_d[REG_SWEEP][2:0];
    sum_nxt = {1'b0, per_nxt} + {1'b0, shf_nxt};
    mute    = (len_d == 8'd0) | ~duty_d[step_d] | (per_nxt < 11'd8) |
              (~regs_d[REG_SWEEP][3] & sum_nxt[PeriodWidth]);
    result_o.level  = mute ? 4'd0 : vol_d;
    result_o.active = (len_d != 8'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      neg_q       <= 1'b1;
      regs_q      <= '0;
      count_q     <= '0;
      step_q      <= '0;
      duty_q      <= '0;
      env_start_q <= 1'b0;
      env_div_q   <= '0;
      env_decay_q <= '0;
      vol_q       <= '0;
      len_q       <= '0;
      len_en_q    <= 1'b0;
      sw_div_q    <= '0;
      sw_reload_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        neg_q <= cfg_wdata_i;
      end
      regs_q      <= regs_d;
      count_q     <= count_d;
      step_q      <= step_d;
      duty_q      <= duty_d;
      env_start_q <= env_start_d;
      env_div_q   <= env_div_d;
      env_decay_q <= env_decay_d;
      vol_q       <= vol_d;
      len_q       <= len_d;
      len_en_q    <= len_en_d;
      sw_div_q    <= sw_div_d;
      sw_reload_q <= sw_reload_d;
    end
  end

endmodule

// ----- rtl/square_wave_channel.sv -----
// Square-wave tone channel: period timer, duty sequencer, envelope, sweep and
// length counter, driven one event per transfer.
//
// Input channel (in_valid_i / in_stall_o): opcode_i selects timer tick,
// quarter frame, half frame, register write (reg_index_i, write_data_i) or
// enable write (enable_bit_i). Every event gives exactly one result.
// Output channel (out_valid_o / out_stall_i): sample_level_o and
// length_active_o as they stand after the event.
// Config channel (cfg_valid_i / cfg_ready_o): cfg_wdata_i high selects ones'
// complement sweep negate, low two's; ready is always high. Write it while idle.
//
// Each result is registered into the output register, or into the skid entry while the output is held.
// Throughput: one event per cycle while in_stall_o is low; the state update is a single pass.
// A two-entry output buffer (output register plus skid) keeps the input
// open while one result waits; in_stall_o rises only when both are full,
// so a stalled receiver holds off the source after one extra event.
// Reset: all channel state clears, negate mode is ones' complement,
// both buffer entries empty.
module square_wave_channel (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] opcode_i,
  input  logic [1:0] reg_index_i,
  input  logic [7:0] write_data_i,
  input  logic       enable_bit_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [3:0] sample_level_o,
  output logic       length_active_o
);
  import swc_pkg::*;

  swc_result_t res, out_q, skid_q;
  logic        out_valid_q, skid_valid_q;
  logic        accept, pop;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = skid_valid_q;
  assign accept      = in_valid_i & ~skid_valid_q;
  assign pop         = out_valid_q & ~out_stall_i;

  swc_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_valid_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .accept_i     (accept),
    .opcode_i     (opcode_i),
    .reg_index_i  (reg_index_i),
    .write_data_i (write_data_i),
    .enable_bit_i (enable_bit_i),
    .result_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || pop) begin
      out_valid_q  <= skid_valid_q | accept;
      skid_valid_q <= 1'b0;
    end else if (accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || pop) begin
      out_q <= skid_valid_q ? skid_q : res;
    end else if (accept) begin
      skid_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign sample_level_o  = out_q.level;
  assign length_active_o = out_q.active;

endmodule

// ----- rtl/swc_checker.sv -----
module swc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [3:0] sample_level_o,
  input logic       length_active_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(sample_level_o) &&
    $stable(length_active_o))
    else $error("stalled output transfer changed");

  a_accept_yields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("accepted event produced no result");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output");

  a_silent_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !length_active_o |-> sample_level_o == 4'd0)
    else $error("level nonzero with length counter at zero");

endmodule

bind square_wave_channel swc_checker u_swc_checker (.*);

// ----- verif/square_wave_monitor.sv -----
module square_wave_monitor (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  input  logic       cfg_ready_i,
  input  logic       cfg_wdata_i,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [2:0] opcode_i,
  input  logic [1:0] reg_index_i,
  input  logic [7:0] write_data_i,
  input  logic       enable_bit_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic [3:0] sample_level_i,
  input  logic       length_active_i,
  output int         mismatch_count_o,
  output int         outstanding_o
);
  import swc_pkg::*;

  localparam logic [7:0] DutyTable [4] = '{8'h80, 8'hC0, 8'hF0, 8'h3F};
  localparam logic [7:0] LenTable [32] = '{
    8'd10, 8'd254, 8'd20, 8'd2, 8'd40, 8'd4, 8'd80, 8'd6,
    8'd160, 8'd8, 8'd60, 8'd10, 8'd14, 8'd12, 8'd26, 8'd14,
    8'd12, 8'd16, 8'd24, 8'd18, 8'd48, 8'd20, 8'd96, 8'd22,
    8'd192, 8'd24, 8'd72, 8'd26, 8'd16, 8'd28, 8'd32, 8'd30
  };

  logic       negate_ones;
  logic [7:0] regs [4];
  logic [10:0] period_count;
  logic [2:0] step_index;
  logic [7:0] duty_bits;
  logic       env_start;
  logic [3:0] env_div;
  logic [3:0] env_decay;
  logic [3:0] held_volume;
  logic [7:0] len_count;
  logic       len_en;
  logic [2:0] sweep_div;
  logic       sweep_reload;

  swc_result_t expected_samples [$];
  swc_result_t want;
  swc_result_t got;

  function automatic logic [10:0] period_value();
    return {regs[3][2:0], regs[2]};
  endfunction

  function automatic int sweep_goal();
    int p;
    int d;
    p = int'(period_value());
    d = p >> regs[1][2:0];
    if (regs[1][3]) return negate_ones ? p - d - 1 : p - d;
    return p + d;
  endfunction

  function automatic bit sweep_silenced();
    if (period_value() < 11'd8) return 1'b1;
    return !regs[1][3] && sweep_goal() > int'(PeriodMax);
  endfunction

  task automatic step_envelope();
    if (env_start) begin
      env_start = 1'b0;
      env_decay = DecayMax;
      env_div = regs[0][3:0];
    end else if (env_div != 4'd0) begin
      env_div = env_div - 4'd1;
    end else begin
      env_div = regs[0][3:0];
      if (env_decay != 4'd0) env_decay = env_decay - 4'd1;
      else if (regs[0][5]) env_decay = DecayMax;
    end
    held_volume = regs[0][4] ? regs[0][3:0] : env_decay;
  endtask

  task automatic advance_channel(input logic [2:0] op, input logic [1:0] idx,
                                 input logic [7:0] data, input logic en);
    int goal;
    logic [10:0] next_period;
    bit mute;
    swc_result_t res;
    case (op)
      OP_TICK: begin
        if (period_count != 11'd0) begin
          period_count = period_count - 11'd1;
        end else begin
          period_count = period_value();
          step_index = step_index - 3'd1;
        end
      end
      OP_QUARTER: step_envelope();
      OP_HALF: begin
        step_envelope();
        if (sweep_div == 3'd0 && !sweep_silenced() && regs[1][7] &&
            regs[1][2:0] != 3'd0) begin
          goal = sweep_goal();
          next_period = (goal < 0) ? 11'd0 : goal[10:0];
          regs[2] = next_period[7:0];
          regs[3][2:0] = next_period[10:8];
        end
        if (sweep_reload || sweep_div == 3'd0) begin
          sweep_div = regs[1][6:4];
          sweep_reload = 1'b0;
        end else begin
          sweep_div = sweep_div - 3'd1;
        end
        if (len_en && len_count != 8'd0 && !regs[0][5]) len_count = len_count - 8'd1;
      end
      OP_WRITE: begin
        case (idx)
          REG_DUTY_ENV: duty_bits = DutyTable[data[7:6]];
          REG_SWEEP:    sweep_reload = 1'b1;
          REG_PER_HI: begin
            step_index = 3'd0;
            env_start = 1'b1;
            if (len_en) len_count = LenTable[data[7:3]];
          end
          default: ;
        endcase
        regs[idx] = data;
      end
      OP_ENABLE: begin
        len_en = en;
        if (!en) len_count = 8'd0;
      end
      default: ;
    endcase
    mute = len_count == 8'd0 || !duty_bits[step_index] || sweep_silenced();
    res.level = mute ? 4'd0 : held_volume;
    res.active = len_count != 8'd0;
    expected_samples.push_back(res);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      negate_ones = 1'b1;
      for (int i = 0; i < 4; i++) regs[i] = 8'd0;
      period_count = '0;
      step_index = '0;
      duty_bits = '0;
      env_start = 1'b0;
      env_div = '0;
      env_decay = '0;
      held_volume = '0;
      len_count = '0;
      len_en = 1'b0;
      sweep_div = '0;
      sweep_reload = 1'b0;
      expected_samples.delete();
      mismatch_count_o = 0;
      outstanding_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) negate_ones = cfg_wdata_i;
      if (out_valid_i && !out_stall_i) begin
        got.level = sample_level_i;
        got.active = length_active_i;
        if (expected_samples.size() == 0) begin
          $display("%0t: unexpected result level %0d active %0d", $time,
                   got.level, got.active);
          mismatch_count_o = mismatch_count_o + 1;
        end else begin
          want = expected_samples.pop_front();
          if (got.level !== want.level) begin
            $display("%0t: sample_level expected %0d actual %0d", $time,
                     want.level, got.level);
            mismatch_count_o = mismatch_count_o + 1;
          end
          if (got.active !== want.active) begin
            $display("%0t: length_active expected %0d actual %0d", $time,
                     want.active, got.active);
            mismatch_count_o = mismatch_count_o + 1;
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        advance_channel(opcode_i, reg_index_i, write_data_i, enable_bit_i);
      outstanding_o = expected_samples.size();
    end
  end

endmodule

// ----- verif/testbench.sv -----
module testbench;
  import swc_pkg::*;

  localparam logic [2:0] OpSpareLo = 3'd5;
  localparam logic [2:0] OpSpareHi = 3'd7;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic       cfg_wdata_i = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [2:0] opcode_i = '0;
  logic [1:0] reg_index_i = '0;
  logic [7:0] write_data_i = '0;
  logic       enable_bit_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [3:0] sample_level_o;
  logic       length_active_o;

  int mismatches;
  int outstanding;
  int events_sent = 0;
  int mode_writes = 0;
  bit quiet = 1'b0;
  bit hold_pending = 1'b0;
  int hold_left = 0;

  square_wave_channel u_dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_wdata_i,
    .in_valid_i, .in_stall_o, .opcode_i, .reg_index_i, .write_data_i,
    .enable_bit_i, .out_valid_o, .out_stall_i, .sample_level_o, .length_active_o
  );

  square_wave_monitor u_monitor (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_wdata_i,
    .in_valid_i, .in_stall_i(in_stall_o), .opcode_i, .reg_index_i,
    .write_data_i, .enable_bit_i, .out_valid_i(out_valid_o), .out_stall_i,
    .sample_level_i(sample_level_o), .length_active_i(length_active_o),
    .mismatch_count_o(mismatches), .outstanding_o(outstanding)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #400000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // receiver: random stalls, plus one long hold on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left = hold_left - 1;
      end else if (hold_pending) begin
        hold_pending = 1'b0;
        hold_left = 79;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !quiet && ($urandom_range(99) < 18);
      end
    end
  end

  task automatic send_event(input logic [2:0] op, input logic [1:0] idx,
                            input logic [7:0] data, input logic en);
    while (!quiet && $urandom_range(99) < 18) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= op;
    reg_index_i <= idx;
    write_data_i <= data;
    enable_bit_i <= en;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    events_sent++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic set_negate_mode(input logic ones);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_wdata_i <= ones;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    mode_writes++;
  endtask

  task automatic random_event();
    int pick;
    logic [2:0] op;
    logic [1:0] idx;
    logic [7:0] data;
    logic en;
    pick = $urandom_range(99);
    idx = 2'($urandom_range(3));
    data = 8'($urandom_range(255));
    en = $urandom_range(99) < 80;
    if (pick < 40) op = OP_TICK;
    else if (pick < 55) op = OP_QUARTER;
    else if (pick < 68) op = OP_HALF;
    else if (pick < 90) op = OP_WRITE;
    else if (pick < 96) op = OP_ENABLE;
    else op = 3'($urandom_range(OpSpareHi, OpSpareLo));
    // keep periods short most of the time so the sequencer moves
    if (op == OP_WRITE && idx == REG_PER_HI && $urandom_range(9) < 7) data[2:0] = 3'd0;
    send_event(op, idx, data, en);
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: reset state, extremes, envelope/sweep/length corners
    send_event(OP_TICK, REG_DUTY_ENV, 8'h00, 1'b0);
    send_event(OP_ENABLE, REG_DUTY_ENV, 8'h00, 1'b1);
    send_event(OP_WRITE, REG_DUTY_ENV, 8'hFF, 1'b0);
    send_event(OP_WRITE, REG_PER_LO, 8'hFF, 1'b0);
    send_event(OP_WRITE, REG_PER_HI, 8'hFF, 1'b0);
    send_event(OP_TICK, REG_DUTY_ENV, 8'h00, 1'b0);
    send_event(OP_WRITE, REG_SWEEP, 8'hFF, 1'b1);
    send_event(OP_HALF, REG_DUTY_ENV, 8'h00, 1'b0);
    send_event(OP_QUARTER, REG_DUTY_ENV, 8'h00, 1'b0);
    send_event(OP_WRITE, REG_DUTY_ENV, 8'h00, 1'b0);
    send_event(OP_QUARTER, REG_DUTY_ENV, 8'h00, 1'b0);
    send_event(OP_QUARTER, REG_DUTY_ENV, 8'h00, 1'b0);
    send_event(OP_WRITE, REG_PER_LO, 8'h05, 1'b0);
    send_event(OP_WRITE, REG_PER_HI, 8'h08, 1'b0);
    send_event(OP_HALF, REG_DUTY_ENV, 8'h00, 1'b0);
    send_event(OP_WRITE, REG_PER_LO, 8'hFF, 1'b0);
    send_event(OP_WRITE, REG_PER_HI, 8'h07, 1'b0);
    send_event(OP_WRITE, REG_SWEEP, 8'h81, 1'b0);
    send_event(OP_HALF, REG_DUTY_ENV, 8'h00, 1'b0);
    send_event(OP_WRITE, REG_SWEEP, 8'h88, 1'b0);
    send_event(OP_HALF, REG_DUTY_ENV, 8'h00, 1'b0);
    send_event(OP_WRITE, REG_PER_LO, 8'h08, 1'b0);
    send_event(OP_WRITE, REG_SWEEP, 8'h89, 1'b0);
    send_event(OP_HALF, REG_DUTY_ENV, 8'h00, 1'b0);
    send_event(OP_ENABLE, REG_PER_HI, 8'hFF, 1'b0);
    send_event(OpSpareLo, REG_PER_HI, 8'hFF, 1'b1);
    send_event(OpSpareHi, REG_DUTY_ENV, 8'h00, 1'b0);

    set_negate_mode(1'b0);
    repeat (250) random_event();

    set_negate_mode(1'b1);
    hold_pending = 1'b1;
    repeat (250) random_event();

    set_negate_mode(1'b0);
    quiet = 1'b1;
    repeat (120) random_event();
    quiet = 1'b0;
    repeat (80) random_event();

    wait_drained();
    $display("Ran %0d events across %0d negate-mode changes, with a long output hold",
             events_sent, mode_writes);
    $display("and drain pauses between phases; %0d mismatches seen", mismatches);
    if (mismatches == 0 && outstanding == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/swc_pkg.sv
rtl/swc_core.sv
rtl/square_wave_channel.sv
rtl/swc_checker.sv
verif/square_wave_monitor.sv
verif/testbench.sv
